FILE: sv/i2c_light_sensor_master_defines.svh
// Assertion macros shared by the light-sensor I2C master RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef I2C_LIGHT_SENSOR_MASTER_DEFINES_SVH
`define I2C_LIGHT_SENSOR_MASTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ILSM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilsm assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define ILSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilsm assertion failed");

`endif

FILE: sv/ilsm_pkg.sv
// Types, codes and helper functions for the light-sensor I2C master.
// No dependencies; used by i2c_light_sensor_master.
package ilsm_pkg;

    // Bus sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST1  = 4'd1,
        PH_ST2  = 4'd2,
        PH_WB1  = 4'd3,
        PH_WB2  = 4'd4,
        PH_WB3  = 4'd5,
        PH_AK1  = 4'd6,
        PH_AK2  = 4'd7,
        PH_POLL = 4'd8,
        PH_RB1  = 4'd9,
        PH_RB2  = 4'd10,
        PH_KA1  = 4'd11,
        PH_KA2  = 4'd12,
        PH_SP1  = 4'd13,
        PH_SP2  = 4'd14
    } phase_t;

    // Which byte of the transaction is on the bus
    typedef enum logic [1:0] {
        STAGE_ADDR   = 2'd0,
        STAGE_FIRST  = 2'd1,
        STAGE_SECOND = 2'd2
    } stage_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_ACK_TIMEOUT    = 2'd1;
    localparam logic [1:0] CFG_QUANTUM_TICKS  = 2'd2;

    // Register reset values
    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd70;
    localparam logic [7:0] ACK_TIMEOUT_RST    = 8'd250;
    localparam logic [7:0] QUANTUM_TICKS_RST  = 8'd1;

    // Line levels packed as {clock, data, drive}
    localparam logic [2:0] LINES_IDLE     = 3'b111;
    localparam logic [2:0] LINES_RELEASE0 = 3'b010;
    localparam logic [2:0] LINES_RELEASE1 = 3'b110;
    localparam logic [2:0] LINES_START2   = 3'b101;
    localparam logic [2:0] LINES_STOP1    = 3'b001;
    localparam logic [2:0] LINES_STOP2    = 3'b101;

    // lux = floor(5*raw/6) as (raw * ceil(5*2^19/6)) >> 19, exact for raw < 2^18
    localparam int          LUX_SHIFT = 19;
    localparam logic [18:0] LUX_MULT  = 19'd436907;

    function automatic logic [15:0] lux_of(input logic [15:0] raw);
        logic [34:0] prod;
        prod = {19'd0, raw} * {16'd0, LUX_MULT};
        return prod[LUX_SHIFT +: 16];
    endfunction

endpackage

FILE: sv/i2c_light_sensor_master.sv
// Light-sensor I2C master: tick-driven bus sequencer with registered in/out words.
// Depends on ilsm_pkg and i2c_light_sensor_master_defines.svh.
//
// Usage:
//   Each input word is one bus tick: request, mode, command_byte and the sampled
//   sda_level. A request on an idle tick starts a transaction: mode 0 sends the
//   address byte and command_byte, mode 1 reads a two-byte measurement.
//   Each input word yields exactly one output word with the line levels to drive
//   (clock_line, data_out, data_drive), busy_res, done_res, ack_error, the last
//   raw_count and its lux value.
//   Path: an accepted word is held in the input word register, processed into the
//   output register and shows on the output port from there.
//   Throughput: one word per cycle unless out_ready stalls; the whole sequencer step,
//   including the lux multiply, sits between the input word register and the output register.
//   Stall: when out_ready is low the output register holds and the input register
//   keeps its word; in_ready drops only while both are full.
//   Config: cfg_ready is always high; write cfg_index/cfg_data while idle.
//   Reset: sequencer idle, lines driven high, measurement zero, registers at
//   address 70, ack timeout 250, one tick per quantum.
`include "i2c_light_sensor_master_defines.svh"

module i2c_light_sensor_master (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        request,
    input  logic        mode,
    input  logic [7:0]  command_byte,
    input  logic        sda_level,
    // output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        clock_line,
    output logic        data_out,
    output logic        data_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic        ack_error,
    output logic [15:0] raw_count,
    output logic [15:0] lux,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    // Configuration registers
    logic [7:0] device_address_reg;
    logic [7:0] ack_timeout_reg;
    logic [7:0] quantum_ticks_reg;

    // Input word register
    logic       s1_valid_reg;
    logic       s1_request_reg;
    logic       s1_mode_reg;
    logic [7:0] s1_command_reg;
    logic       s1_sda_reg;

    // Sequencer state
    ilsm_pkg::phase_t phase_reg, phase_next;
    ilsm_pkg::stage_t stage_reg, stage_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [9:0]  delay_reg, delay_next;
    logic [7:0]  poll_reg, poll_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  command_reg, command_next;
    logic        mode_reg, mode_next;
    logic [15:0] measurement_reg, measurement_next;
    logic        error_reg, error_next;
    logic [2:0]  lines_reg, lines_next;
    logic        done_next;
    logic        poll_now;
    logic        ack_now;

    // Output register
    logic        out_valid_reg;
    logic [2:0]  out_lines_reg;
    logic        out_busy_reg;
    logic        out_done_reg;
    logic        out_error_reg;
    logic [15:0] out_raw_reg;
    logic [15:0] out_lux_reg;

    // Handshake
    logic advance;
    logic process;
    logic in_take;

    // Segment lengths of 1, 2 and 4 quanta
    logic [7:0] q_eff;
    logic [9:0] dly1, dly2, dly4;

    assign advance   = !out_valid_reg || out_ready;
    assign process   = s1_valid_reg && advance;
    assign in_ready  = !s1_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign q_eff = (quantum_ticks_reg == 8'd0) ? 8'd1 : quantum_ticks_reg;
    assign dly1  = {2'b00, q_eff};
    assign dly2  = {1'b0, q_eff, 1'b0};
    assign dly4  = {q_eff, 2'b00};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= ilsm_pkg::DEVICE_ADDRESS_RST;
            ack_timeout_reg    <= ilsm_pkg::ACK_TIMEOUT_RST;
            quantum_ticks_reg  <= ilsm_pkg::QUANTUM_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ilsm_pkg::CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data;
                ilsm_pkg::CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_data;
                ilsm_pkg::CFG_QUANTUM_TICKS:  quantum_ticks_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (process)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_request_reg <= request;
            s1_mode_reg    <= mode;
            s1_command_reg <= command_byte;
            s1_sda_reg     <= sda_level;
        end
    end

    // Sequencer step for one tick
    always_comb
    begin
        phase_next       = phase_reg;
        stage_next       = stage_reg;
        bit_index_next   = bit_index_reg;
        delay_next       = delay_reg;
        poll_next        = poll_reg;
        shift_next       = shift_reg;
        command_next     = command_reg;
        mode_next        = mode_reg;
        measurement_next = measurement_reg;
        error_next       = error_reg;
        lines_next       = lines_reg;
        done_next        = 1'b0;
        poll_now         = 1'b0;
        ack_now          = 1'b0;

        case (phase_reg)
            ilsm_pkg::PH_IDLE:
            begin
                if (s1_request_reg)
                begin
                    mode_next      = s1_mode_reg;
                    command_next   = s1_command_reg;
                    error_next     = 1'b0;
                    stage_next     = ilsm_pkg::STAGE_ADDR;
                    poll_next      = 8'd0;
                    bit_index_next = 4'd0;
                    phase_next     = ilsm_pkg::PH_ST1;
                    delay_next     = dly4;
                    lines_next     = ilsm_pkg::LINES_IDLE;
                end
            end
            ilsm_pkg::PH_POLL:
            begin
                poll_now = 1'b1;
            end
            default:
            begin
                if (delay_reg > 10'd1)
                begin
                    delay_next = delay_reg - 10'd1;
                end
                else
                begin
                    // end of the current segment
                    case (phase_reg)
                        ilsm_pkg::PH_ST1:
                        begin
                            phase_next = ilsm_pkg::PH_ST2;
                            delay_next = dly4;
                            lines_next = ilsm_pkg::LINES_START2;
                        end
                        ilsm_pkg::PH_ST2:
                        begin
                            bit_index_next = 4'd0;
                            shift_next     = device_address_reg + {7'd0, mode_reg};
                            phase_next     = ilsm_pkg::PH_WB1;
                            delay_next     = dly2;
                            lines_next     = {1'b0, shift_next[7], 1'b1};
                        end
                        ilsm_pkg::PH_WB1:
                        begin
                            phase_next = ilsm_pkg::PH_WB2;
                            delay_next = dly2;
                            lines_next = {1'b1, shift_reg[7], 1'b1};
                        end
                        ilsm_pkg::PH_WB2:
                        begin
                            phase_next = ilsm_pkg::PH_WB3;
                            delay_next = dly2;
                            lines_next = {1'b0, shift_reg[7], 1'b1};
                        end
                        ilsm_pkg::PH_WB3:
                        begin
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_index_next = bit_index_reg + 4'd1;
                            if (bit_index_next[3])
                            begin
                                poll_next  = 8'd0;
                                phase_next = ilsm_pkg::PH_AK1;
                                delay_next = dly1;
                                lines_next = ilsm_pkg::LINES_RELEASE0;
                            end
                            else
                            begin
                                phase_next = ilsm_pkg::PH_WB1;
                                delay_next = dly2;
                                lines_next = {1'b0, shift_next[7], 1'b1};
                            end
                        end
                        ilsm_pkg::PH_AK1:
                        begin
                            phase_next = ilsm_pkg::PH_AK2;
                            delay_next = dly1;
                            lines_next = ilsm_pkg::LINES_RELEASE1;
                        end
                        ilsm_pkg::PH_AK2:
                        begin
                            poll_now = 1'b1;
                        end
                        ilsm_pkg::PH_RB1:
                        begin
                            phase_next = ilsm_pkg::PH_RB2;
                            delay_next = dly1;
                            lines_next = ilsm_pkg::LINES_RELEASE1;
                        end
                        ilsm_pkg::PH_RB2:
                        begin
                            shift_next     = {shift_reg[6:0], s1_sda_reg};
                            bit_index_next = bit_index_reg + 4'd1;
                            if (bit_index_next[3])
                            begin
                                // ack the first byte, nack the last
                                phase_next = ilsm_pkg::PH_KA1;
                                delay_next = dly2;
                                lines_next = {1'b0, (stage_reg != ilsm_pkg::STAGE_FIRST), 1'b1};
                            end
                            else
                            begin
                                phase_next = ilsm_pkg::PH_RB1;
                                delay_next = dly2;
                                lines_next = ilsm_pkg::LINES_RELEASE0;
                            end
                        end
                        ilsm_pkg::PH_KA1:
                        begin
                            phase_next = ilsm_pkg::PH_KA2;
                            delay_next = dly2;
                            lines_next = {1'b1, lines_reg[1], 1'b1};
                        end
                        ilsm_pkg::PH_KA2:
                        begin
                            if (stage_reg == ilsm_pkg::STAGE_FIRST)
                            begin
                                command_next   = shift_reg;
                                stage_next     = ilsm_pkg::STAGE_SECOND;
                                shift_next     = 8'd0;
                                bit_index_next = 4'd0;
                                phase_next     = ilsm_pkg::PH_RB1;
                                delay_next     = dly2;
                                lines_next     = ilsm_pkg::LINES_RELEASE0;
                            end
                            else
                            begin
                                measurement_next = {command_reg, shift_reg};
                                phase_next       = ilsm_pkg::PH_SP1;
                                delay_next       = dly4;
                                lines_next       = ilsm_pkg::LINES_STOP1;
                            end
                        end
                        ilsm_pkg::PH_SP1:
                        begin
                            phase_next = ilsm_pkg::PH_SP2;
                            delay_next = dly4;
                            lines_next = ilsm_pkg::LINES_STOP2;
                        end
                        ilsm_pkg::PH_SP2:
                        begin
                            phase_next = ilsm_pkg::PH_IDLE;
                            delay_next = 10'd0;
                            lines_next = ilsm_pkg::LINES_IDLE;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            phase_next = ilsm_pkg::PH_IDLE;
                            delay_next = 10'd0;
                            lines_next = ilsm_pkg::LINES_IDLE;
                        end
                    endcase
                end
            end
        endcase

        // Acknowledge poll: low is ack, high counts until the timeout
        if (poll_now)
        begin
            if (!s1_sda_reg)
            begin
                ack_now = 1'b1;
            end
            else if (poll_reg >= ack_timeout_reg)
            begin
                error_next = 1'b1;
                phase_next = ilsm_pkg::PH_SP1;
                delay_next = dly4;
                lines_next = ilsm_pkg::LINES_STOP1;
            end
            else
            begin
                poll_next  = poll_reg + 8'd1;
                phase_next = ilsm_pkg::PH_POLL;
                lines_next = ilsm_pkg::LINES_RELEASE1;
            end
        end

        // Acknowledged: move on to the data byte or stop
        if (ack_now)
        begin
            if (stage_reg == ilsm_pkg::STAGE_ADDR)
            begin
                stage_next     = ilsm_pkg::STAGE_FIRST;
                bit_index_next = 4'd0;
                if (!mode_reg)
                begin
                    shift_next = command_reg;
                    phase_next = ilsm_pkg::PH_WB1;
                    delay_next = dly2;
                    lines_next = {1'b0, command_reg[7], 1'b1};
                end
                else
                begin
                    shift_next = 8'd0;
                    phase_next = ilsm_pkg::PH_RB1;
                    delay_next = dly2;
                    lines_next = ilsm_pkg::LINES_RELEASE0;
                end
            end
            else
            begin
                phase_next = ilsm_pkg::PH_SP1;
                delay_next = dly4;
                lines_next = ilsm_pkg::LINES_STOP1;
            end
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ilsm_pkg::PH_IDLE;
            stage_reg       <= ilsm_pkg::STAGE_ADDR;
            bit_index_reg   <= 4'd0;
            delay_reg       <= 10'd0;
            poll_reg        <= 8'd0;
            shift_reg       <= 8'd0;
            command_reg     <= 8'd0;
            mode_reg        <= 1'b0;
            measurement_reg <= 16'd0;
            error_reg       <= 1'b0;
            lines_reg       <= ilsm_pkg::LINES_IDLE;
        end
        else if (process)
        begin
            phase_reg       <= phase_next;
            stage_reg       <= stage_next;
            bit_index_reg   <= bit_index_next;
            delay_reg       <= delay_next;
            poll_reg        <= poll_next;
            shift_reg       <= shift_next;
            command_reg     <= command_next;
            mode_reg        <= mode_next;
            measurement_reg <= measurement_next;
            error_reg       <= error_next;
            lines_reg       <= lines_next;
        end
    end

    // Output register: valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: word
    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_lines_reg <= lines_next;
            out_busy_reg  <= (phase_next != ilsm_pkg::PH_IDLE);
            out_done_reg  <= done_next;
            out_error_reg <= done_next && error_next;
            out_raw_reg   <= measurement_next;
            out_lux_reg   <= ilsm_pkg::lux_of(measurement_next);
        end
    end

    assign out_valid  = out_valid_reg;
    assign clock_line = out_lines_reg[2];
    assign data_out   = out_lines_reg[1];
    assign data_drive = out_lines_reg[0];
    assign busy_res   = out_busy_reg;
    assign done_res   = out_done_reg;
    assign ack_error  = out_error_reg;
    assign raw_count  = out_raw_reg;
    assign lux        = out_lux_reg;

    // Assertions
    `ILSM_ASSERT_NOW(a_idle_lines, phase_reg == ilsm_pkg::PH_IDLE,
        lines_reg == ilsm_pkg::LINES_IDLE)
    `ILSM_ASSERT_NOW(a_poll_lines, phase_reg == ilsm_pkg::PH_POLL,
        lines_reg == ilsm_pkg::LINES_RELEASE1)
    `ILSM_ASSERT_NOW(a_timed_delay,
        phase_reg != ilsm_pkg::PH_IDLE && phase_reg != ilsm_pkg::PH_POLL,
        delay_reg != 10'd0)
    `ILSM_ASSERT_NOW(a_done_idle, out_valid_reg && out_done_reg,
        !out_busy_reg && out_lines_reg == ilsm_pkg::LINES_IDLE)
    `ILSM_ASSERT_NOW(a_error_with_done, out_valid_reg && out_error_reg, out_done_reg)
    `ILSM_ASSERT_NEXT(a_word_kept, s1_valid_reg && !process, s1_valid_reg)

endmodule
